// File: src/i2cmbe_pkg.sv
package i2cmbe_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int UNIT_W      = 10;
    localparam int TIMEOUT_W   = 8;
    localparam int DELAY_W     = 12;
    localparam int BITCNT_W    = 4;
    localparam int REQ_W       = 3;

    localparam logic [UNIT_W-1:0]    UNIT_TICKS_RESET  = 10'd1;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

    // Raw request codes on the input port.
    localparam logic [REQ_W-1:0] REQ_START    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STOP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WAIT_ACK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_WAIT_ACK,
        CMD_READ
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST1,
        PH_ST2,
        PH_SP1,
        PH_SP2,
        PH_WA1,
        PH_WA2,
        PH_WAP,
        PH_WB1,
        PH_WB2,
        PH_WB3,
        PH_RB1,
        PH_RB2,
        PH_RA1,
        PH_RA2
    } t_phase;

    typedef struct packed {
        t_cmd                 cmd;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_in;
    } t_item;

    typedef struct packed {
        logic [UNIT_W-1:0]    unit_ticks;
        logic [TIMEOUT_W-1:0] ack_timeout;
    } t_cfg;

endpackage

// File: src/i2c_master_bit_engine.sv
// Channel     Handshake                     Payload
// ----------  ----------------------------  -----------------------------------------
// request     i_in_valid / o_in_stall       i_cmd_valid i_req_type i_tx_byte
//                                           i_send_ack i_sda_in
// result      o_out_valid / i_out_stall     o_scl o_sda_out o_sda_is_input o_busy_res
//                                           o_cmd_done o_rx_byte o_ack_failed
// config      i_cfg_valid / o_cfg_ready     i_cfg_index i_cfg_data
//
// One request is one bus tick and is taken every clock cycle unless o_in_stall is
// high; its result passes through the queue stage, then the engine's result register.
// A two-entry queue separates the request side from the engine, so either side
// may stall without stopping the other. Reset is synchronous and active low and
// puts the bus in the released state with unit_ticks 1 and ack_timeout 250.
// Configuration writes are always ready.
module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd_valid,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [BYTE_BITS-1:0] i_tx_byte,
    input  logic                 i_send_ack,
    input  logic                 i_sda_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_scl,
    output logic                 o_sda_out,
    output logic                 o_sda_is_input,
    output logic                 o_busy_res,
    output logic                 o_cmd_done,
    output logic [BYTE_BITS-1:0] o_rx_byte,
    output logic                 o_ack_failed,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [UNIT_W-1:0]    i_cfg_data
);

    t_cfg   r_cfg;
    logic   q_valid;
    t_item  q_item;
    logic   q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_ticks  <= UNIT_TICKS_RESET;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_UNIT_TICKS:  r_cfg.unit_ticks  <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    i2cmbe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd_valid (i_cmd_valid),
        .i_req_type  (i_req_type),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_in    (i_sda_in),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    i2cmbe_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scl          (o_scl),
        .o_sda_out      (o_sda_out),
        .o_sda_is_input (o_sda_is_input),
        .o_busy_res     (o_busy_res),
        .o_cmd_done     (o_cmd_done),
        .o_rx_byte      (o_rx_byte),
        .o_ack_failed   (o_ack_failed)
    );

endmodule

// File: src/i2cmbe_front.sv
module i2cmbe_front
    import i2cmbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd_valid,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [BYTE_BITS-1:0] i_tx_byte,
    input  logic                 i_send_ack,
    input  logic                 i_sda_in,
    output logic                 o_q_valid,
    output t_item                o_q_item,
    input  logic                 i_q_pop
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        push;
    t_item       item;

    // A request without a command or with an unknown code maps to CMD_NONE and starts no command.
    always_comb begin
        item.tx_byte  = i_tx_byte;
        item.send_ack = i_send_ack;
        item.sda_in   = i_sda_in;
        item.cmd      = CMD_NONE;
        if (i_cmd_valid) begin
            unique case (i_req_type)
                REQ_START:    item.cmd = CMD_START;
                REQ_STOP:     item.cmd = CMD_STOP;
                REQ_WRITE:    item.cmd = CMD_WRITE;
                REQ_WAIT_ACK: item.cmd = CMD_WAIT_ACK;
                REQ_READ:     item.cmd = CMD_READ;
                default:      item.cmd = CMD_NONE;
            endcase
        end
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !(i_q_pop && o_q_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_q_pop && o_q_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop && o_q_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

// File: src/i2cmbe_engine.sv
module i2cmbe_engine
    import i2cmbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_scl,
    output logic                 o_sda_out,
    output logic                 o_sda_is_input,
    output logic                 o_busy_res,
    output logic                 o_cmd_done,
    output logic [BYTE_BITS-1:0] o_rx_byte,
    output logic                 o_ack_failed
);

    t_phase                 r_phase, n_phase;
    logic [BITCNT_W-1:0]    r_bit_count, n_bit_count;
    logic [BYTE_BITS-1:0]   r_shift, n_shift;
    logic [DELAY_W-1:0]     r_delay, n_delay;
    logic [TIMEOUT_W-1:0]   r_poll, n_poll;
    logic                   r_ack_choice, n_ack_choice;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_sda_dir, n_sda_dir;
    logic                   r_fail, n_fail;
    logic [BYTE_BITS-1:0]   r_rx_hold, n_rx_hold;
    logic                   r_done, n_done;
    logic                   r_out_valid;

    logic [UNIT_W-1:0]      unit;
    logic [DELAY_W-1:0]     dly1, dly2, dly4;
    logic [DELAY_W-1:0]     dec;
    logic [BITCNT_W-1:0]    bit_inc;

    // A step is taken whenever a request is queued and the output slot is free or being drained.
    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // Delay lengths of one, two and four units; four times the largest unit still fits.
    assign unit    = (i_cfg.unit_ticks == '0) ? UNIT_W'(1) : i_cfg.unit_ticks;
    assign dly1    = DELAY_W'(unit);
    assign dly2    = DELAY_W'({unit, 1'b0});
    assign dly4    = DELAY_W'({unit, 2'b00});
    assign dec     = (r_delay != '0) ? r_delay - DELAY_W'(1) : r_delay;
    assign bit_inc = r_bit_count + BITCNT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_dir    = r_sda_dir;
        n_fail       = r_fail;
        n_rx_hold    = r_rx_hold;
        n_done       = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_q_item.cmd != CMD_NONE) begin
                n_fail = 1'b0;
            end
            unique case (i_q_item.cmd)
                CMD_START: begin
                    n_sda_dir = 1'b0;
                    n_sda     = 1'b1;
                    n_scl     = 1'b1;
                    n_delay   = dly4;
                    n_phase   = PH_ST1;
                end
                CMD_STOP: begin
                    n_sda_dir = 1'b0;
                    n_scl     = 1'b0;
                    n_sda     = 1'b0;
                    n_delay   = dly4;
                    n_phase   = PH_SP1;
                end
                CMD_WRITE: begin
                    n_sda_dir   = 1'b0;
                    n_scl       = 1'b0;
                    n_bit_count = '0;
                    n_sda       = i_q_item.tx_byte[BYTE_BITS-1];
                    n_shift     = {i_q_item.tx_byte[BYTE_BITS-2:0], 1'b0};
                    n_delay     = dly2;
                    n_phase     = PH_WB1;
                end
                CMD_WAIT_ACK: begin
                    n_sda_dir = 1'b1;
                    n_sda     = 1'b1;
                    n_delay   = dly1;
                    n_phase   = PH_WA1;
                end
                CMD_READ: begin
                    n_sda_dir    = 1'b1;
                    n_sda        = 1'b1;
                    n_scl        = 1'b0;
                    n_shift      = '0;
                    n_bit_count  = '0;
                    n_ack_choice = i_q_item.send_ack;
                    n_delay      = dly2;
                    n_phase      = PH_RB1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (r_phase == PH_WAP) begin
            if (!i_q_item.sda_in) begin
                n_scl   = 1'b0;
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end else if (r_poll >= i_cfg.ack_timeout) begin
                // Timed out: flag it and go straight into a stop condition.
                n_fail    = 1'b1;
                n_sda_dir = 1'b0;
                n_scl     = 1'b0;
                n_sda     = 1'b0;
                n_delay   = dly4;
                n_phase   = PH_SP1;
            end else begin
                n_poll = r_poll + TIMEOUT_W'(1);
            end
        end else begin
            n_delay = dec;
            if (dec == '0) begin
                unique case (r_phase)
                    PH_ST1: begin
                        n_sda   = 1'b0;
                        n_delay = dly4;
                        n_phase = PH_ST2;
                    end
                    PH_ST2: begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_SP1: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_delay = dly4;
                        n_phase = PH_SP2;
                    end
                    PH_SP2: begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_WA1: begin
                        n_scl   = 1'b1;
                        n_delay = dly1;
                        n_phase = PH_WA2;
                    end
                    PH_WA2: begin
                        n_poll  = '0;
                        n_phase = PH_WAP;
                    end
                    PH_WB1: begin
                        n_scl   = 1'b1;
                        n_delay = dly2;
                        n_phase = PH_WB2;
                    end
                    PH_WB2: begin
                        n_scl   = 1'b0;
                        n_delay = dly2;
                        n_phase = PH_WB3;
                    end
                    PH_WB3: begin
                        n_bit_count = bit_inc;
                        if (bit_inc >= BITCNT_W'(BYTE_BITS)) begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_sda   = r_shift[BYTE_BITS-1];
                            n_shift = {r_shift[BYTE_BITS-2:0], 1'b0};
                            n_delay = dly2;
                            n_phase = PH_WB1;
                        end
                    end
                    PH_RB1: begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[BYTE_BITS-2:0], i_q_item.sda_in};
                        n_delay = dly1;
                        n_phase = PH_RB2;
                    end
                    PH_RB2: begin
                        n_bit_count = bit_inc;
                        n_scl       = 1'b0;
                        n_delay     = dly2;
                        if (bit_inc >= BITCNT_W'(BYTE_BITS)) begin
                            n_sda_dir = 1'b0;
                            n_sda     = ~r_ack_choice;
                            n_phase   = PH_RA1;
                        end else begin
                            n_phase = PH_RB1;
                        end
                    end
                    PH_RA1: begin
                        n_scl   = 1'b1;
                        n_delay = dly2;
                        n_phase = PH_RA2;
                    end
                    PH_RA2: begin
                        n_scl     = 1'b0;
                        n_rx_hold = r_shift;
                        n_phase   = PH_IDLE;
                        n_done    = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_poll       <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_dir    <= 1'b0;
            r_fail       <= 1'b0;
            r_rx_hold    <= '0;
            r_done       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_delay      <= n_delay;
                r_poll       <= n_poll;
                r_ack_choice <= n_ack_choice;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_sda_dir    <= n_sda_dir;
                r_fail       <= n_fail;
                r_rx_hold    <= n_rx_hold;
                r_done       <= n_done;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The state registers hold still while a result waits, so they serve as the result.
    assign o_out_valid    = r_out_valid;
    assign o_scl          = r_scl;
    assign o_sda_out      = r_sda;
    assign o_sda_is_input = r_sda_dir;
    assign o_busy_res     = (r_phase != PH_IDLE);
    assign o_cmd_done     = r_done;
    assign o_rx_byte      = r_rx_hold;
    assign o_ack_failed   = r_fail;

endmodule
